@@ sv/gfssc_pkg.sv @@
package gfssc_pkg;

   localparam int MAX_SHARES_DEF = 16;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_SETUP = 2'd1,
      ACT_SHARE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_BYTE      = 2'd0,
      ST_SETUP_OK  = 2'd1,
      ST_BAD_X     = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef struct packed {
      logic       x_we;
      logic       xi_load;
      logic       pair_step;
      logic       pair_diff;
      logic       fail_clear;
      logic       acc_clear;
      logic       acc_step;
      logic       w_we;
      logic       y_load;
      logic       emit;
      status_type emit_status;
   } gfssc_cmd_type;

   typedef struct packed {
      logic fail;
      logic out_free;
   } gfssc_stat_type;

   typedef logic [7:0] byte_tbl_type [256];

   // Product in GF(2^8) with the reduction polynomial x^8+x^4+x^3+x+1.
   function automatic logic [7:0] gf_mul(input logic [7:0] p, input logic [7:0] q);
      logic [7:0] a;
      logic [7:0] r;
      a = p;
      r = 8'h00;
      for (int n = 0; n < 8; n++) begin
         if (q[n]) begin
            r = r ^ a;
         end
         a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      end
      return r;
   endfunction

   // Inverse table built from the antilog and log tables over generator 3.
   function automatic byte_tbl_type gen_inv_tbl();
      byte_tbl_type exp_t;
      byte_tbl_type log_t;
      byte_tbl_type inv_t;
      logic [7:0]   e;
      e = 8'h01;
      for (int n = 0; n < 256; n++) begin
         exp_t[n] = 8'h00;
         log_t[n] = 8'h00;
         inv_t[n] = 8'h00;
      end
      for (int n = 0; n < 255; n++) begin
         exp_t[n] = e;
         log_t[e] = 8'(n);
         e = gf_mul(e, 8'h03);
      end
      exp_t[255] = 8'h01;
      for (int v = 1; v < 256; v++) begin
         inv_t[v] = exp_t[255 - int'(log_t[v])];
      end
      return inv_t;
   endfunction

   localparam byte_tbl_type INV_TBL = gen_inv_tbl();

endpackage

@@ sv/gfssc_req_if.sv @@
interface gfssc_req_if import gfssc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [3:0] share_index;
   logic [7:0] share_value;

   modport source (output valid, output action, output share_index, output share_value,
                   input ready);
   modport sink (input valid, input action, input share_index, input share_value,
                 output ready);
endinterface

@@ sv/gfssc_rsp_if.sv @@
interface gfssc_rsp_if import gfssc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] secret_byte;
   logic [1:0] status;

   modport source (output valid, output secret_byte, output status, input ready);
   modport sink (input valid, input secret_byte, input status, output ready);
endinterface

@@ sv/gfssc_ram.sv @@
module gfssc_ram import gfssc_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = MAX_SHARES_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/gfssc_dpath.sv @@
module gfssc_dpath import gfssc_pkg::*; #(
   parameter int MAX_SHARES = MAX_SHARES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gfssc_cmd_type                 cmd,
   input  logic [$clog2(MAX_SHARES)-1:0] x_raddr,
   input  logic [$clog2(MAX_SHARES)-1:0] w_waddr,
   input  logic [$clog2(MAX_SHARES)-1:0] w_raddr,
   input  logic [3:0]                    in_index,
   input  logic [7:0]                    in_value,
   output gfssc_stat_type                stat,
   gfssc_rsp_if.source                   rsp_chan
);

   localparam int IW = $clog2(MAX_SHARES);

   logic [7:0] x_rd;
   logic [7:0] w_rd;
   logic [7:0] w_new;
   logic [7:0] xi_ff;
   logic [7:0] num_ff;
   logic [7:0] den_ff;
   logic [7:0] y_ff;
   logic [7:0] acc_ff;
   logic       fail_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic [1:0] status_ff;
   logic       out_free;

   assign w_new = gf_mul(num_ff, INV_TBL[den_ff]);

   gfssc_ram #(.WIDTH(8), .DEPTH(MAX_SHARES)) u_x_ram (
      .clock (clock),
      .we    (cmd.x_we),
      .waddr (IW'(in_index)),
      .wdata (in_value),
      .raddr (x_raddr),
      .rdata (x_rd)
   );

   gfssc_ram #(.WIDTH(8), .DEPTH(MAX_SHARES)) u_w_ram (
      .clock (clock),
      .we    (cmd.w_we),
      .waddr (w_waddr),
      .wdata (w_new),
      .raddr (w_raddr),
      .rdata (w_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.xi_load) begin
         xi_ff  <= x_rd;
         num_ff <= 8'h01;
         den_ff <= 8'h01;
      end else if (cmd.pair_step && cmd.pair_diff) begin
         num_ff <= gf_mul(num_ff, x_rd);
         den_ff <= gf_mul(den_ff, xi_ff ^ x_rd);
      end
      if (cmd.y_load) begin
         y_ff <= in_value;
      end
      if (cmd.emit) begin
         byte_ff   <= (cmd.emit_status == ST_BYTE) ? acc_ff : 8'h00;
         status_ff <= cmd.emit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff  <= 1'b0;
         acc_ff   <= 8'h00;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.fail_clear) begin
            fail_ff <= 1'b0;
         end else if (cmd.xi_load && x_rd == 8'h00) begin
            fail_ff <= 1'b1;
         end else if (cmd.pair_step && cmd.pair_diff && x_rd == xi_ff) begin
            fail_ff <= 1'b1;
         end
         if (cmd.acc_clear || (cmd.emit && cmd.emit_status == ST_BYTE)) begin
            acc_ff <= 8'h00;
         end else if (cmd.acc_step) begin
            acc_ff <= acc_ff ^ gf_mul(w_rd, y_ff);
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign out_free             = !valid_ff || rsp_chan.ready;
   assign stat.fail            = fail_ff;
   assign stat.out_free        = out_free;
   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.secret_byte = byte_ff;
   assign rsp_chan.status      = status_ff;

endmodule

@@ sv/gfssc_ctrl.sv @@
module gfssc_ctrl import gfssc_pkg::*; #(
   parameter int MAX_SHARES = MAX_SHARES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   gfssc_req_if.sink                     req_chan,
   input  logic                          csr_we,
   input  logic [4:0]                    csr_wdata,
   input  gfssc_stat_type                stat,
   output gfssc_cmd_type                 cmd,
   output logic [$clog2(MAX_SHARES)-1:0] x_raddr,
   output logic [$clog2(MAX_SHARES)-1:0] w_waddr,
   output logic [$clog2(MAX_SHARES)-1:0] w_raddr
);

   localparam int IW = $clog2(MAX_SHARES);
   localparam int KW = $clog2(MAX_SHARES + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RDI   = 7'b0000010,
      S_GETI  = 7'b0000100,
      S_RUNJ  = 7'b0001000,
      S_WR    = 7'b0010000,
      S_SHACC = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [KW-1:0] k_ff, k_in, k_new;
   logic          wready_ff, wready_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] idx_ff, idx_in;
   status_type    st_ff, st_in;
   logic          accept;
   logic          j_last;
   logic          i_last;
   logic          idx_last;

   always_comb begin
      if (csr_wdata < 5'd2) begin
         k_new = KW'(2);
      end else if (int'(csr_wdata) > MAX_SHARES) begin
         k_new = KW'(MAX_SHARES);
      end else begin
         k_new = KW'(csr_wdata);
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);
   assign j_last         = (int'(j_ff) + 1 == int'(k_ff));
   assign i_last         = (int'(i_ff) + 1 == int'(k_ff));
   assign idx_last       = (int'(idx_ff) + 1 == int'(k_ff));
   assign w_waddr        = i_ff;

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      wready_in = wready_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      idx_in    = idx_ff;
      st_in     = st_ff;
      cmd       = '0;
      cmd.emit_status = st_ff;
      cmd.pair_diff   = (j_ff != i_ff);
      x_raddr   = i_ff;
      w_raddr   = IW'(req_chan.share_index);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.y_load = 1'b1;
               case (req_chan.action)
                  ACT_LOAD: begin
                     if (int'(req_chan.share_index) < MAX_SHARES) begin
                        cmd.x_we      = 1'b1;
                        cmd.acc_clear = 1'b1;
                        wready_in     = 1'b0;
                     end
                  end
                  ACT_SETUP: begin
                     cmd.acc_clear  = 1'b1;
                     cmd.fail_clear = 1'b1;
                     i_in           = '0;
                     state_in       = S_RDI;
                  end
                  ACT_SHARE: begin
                     if (!wready_ff) begin
                        st_in    = ST_NOT_READY;
                        state_in = S_EMIT;
                     end else if (int'(req_chan.share_index) < int'(k_ff)) begin
                        idx_in   = IW'(req_chan.share_index);
                        state_in = S_SHACC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDI: begin
            state_in = S_GETI;
         end
         S_GETI: begin
            cmd.xi_load = 1'b1;
            x_raddr     = '0;
            j_in        = '0;
            state_in    = S_RUNJ;
         end
         S_RUNJ: begin
            cmd.pair_step = 1'b1;
            if (j_last) begin
               state_in = S_WR;
            end else begin
               x_raddr  = j_ff + 1'b1;
               j_in     = j_ff + 1'b1;
            end
         end
         S_WR: begin
            cmd.w_we = 1'b1;
            if (i_last) begin
               st_in     = stat.fail ? ST_BAD_X : ST_SETUP_OK;
               wready_in = !stat.fail;
               state_in  = S_EMIT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_RDI;
            end
         end
         S_SHACC: begin
            cmd.acc_step = 1'b1;
            if (idx_last) begin
               st_in    = ST_BYTE;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_we) begin
         k_in          = k_new;
         wready_in     = 1'b0;
         cmd.acc_clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         k_ff      <= KW'(2);
         wready_ff <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         idx_ff    <= '0;
         st_ff     <= ST_BYTE;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         wready_ff <= wready_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         idx_ff    <= idx_in;
         st_ff     <= st_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_csr_clears_ready: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !wready_ff)
      else $error("weights still marked ready after a share count write");
   a_j_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUNJ) |-> (int'(j_ff) < int'(k_ff)))
      else $error("pair index beyond share count");
   a_next_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR && !i_last && !csr_we) |=> (state_ff == S_RDI))
      else $error("weight row not followed by the next row");
   a_setup_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.action == ACT_SETUP) |=> (state_ff == S_RDI && i_ff == '0))
      else $error("setup word did not start the weight pass");
`endif

endmodule

@@ sv/gf256_secret_share_combine_top.sv @@
// Channel    Dir  Handshake              Contents
// req_chan   in   valid/ready            action, share_index, share_value
// rsp_chan   out  valid/ready            secret_byte, status
// csr        in   csr_we, no wait        csr_wdata (share count)
//
// A load or ignored word is handled in the idle state; a share word passes through S_SHACC,
// then S_EMIT when it completes a byte; one that arrives before a good setup goes to S_EMIT.
// A setup word runs S_RDI, S_GETI, S_RUNJ and S_WR for each of the k weight rows, reading
// the coordinate RAM once per coordinate pair in S_RUNJ; its result then goes out from S_EMIT.
// The result register is free again on the cycle its word is taken, so a held result
// stalls only a later word that has a result of its own to deliver.
// Reset is synchronous and active high; share count returns to 2 and weights are not ready.
module gf256_secret_share_combine_top import gfssc_pkg::*; #(
   parameter int MAX_SHARES = MAX_SHARES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gfssc_req_if.sink  req_chan,
   gfssc_rsp_if.source rsp_chan,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);

   localparam int IW = $clog2(MAX_SHARES);

   gfssc_cmd_type  cmd;
   gfssc_stat_type stat;
   logic [IW-1:0]  x_raddr;
   logic [IW-1:0]  w_waddr;
   logic [IW-1:0]  w_raddr;

   gfssc_ctrl #(.MAX_SHARES(MAX_SHARES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .cmd       (cmd),
      .x_raddr   (x_raddr),
      .w_waddr   (w_waddr),
      .w_raddr   (w_raddr)
   );

   gfssc_dpath #(.MAX_SHARES(MAX_SHARES)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .x_raddr  (x_raddr),
      .w_waddr  (w_waddr),
      .w_raddr  (w_raddr),
      .in_index (req_chan.share_index),
      .in_value (req_chan.share_value),
      .stat     (stat),
      .rsp_chan (rsp_chan)
   );

endmodule
